// File: hw/rtl/sha1s_pkg.sv
// Shared types, initial hash values and round constants of the SHA-1 stream hash engine.
package sha1s_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  windex_t;
  typedef logic [6:0]  round_t;

  localparam int unsigned DIGEST_WORDS = 5;
  localparam windex_t     LAST_INDEX   = 3'd4;
  localparam round_t      LAST_ROUND   = 7'd79;
  localparam byte_t       PAD_BYTE     = 8'h80;

  localparam word_t IV [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  function automatic word_t round_k(input round_t t);
    word_t k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// File: hw/rtl/sha1s_if.sv
// Valid/ready channel interfaces for the message bytes and the digest words.
interface sha1s_msg_if;
  logic               valid;
  logic               ready;
  sha1s_pkg::byte_t   data_byte;
  logic               has_byte;
  logic               end_of_message;

  modport source (output valid, output data_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input end_of_message,
                output ready);
endinterface

interface sha1s_digest_if;
  logic               valid;
  logic               ready;
  sha1s_pkg::word_t   digest_word;
  sha1s_pkg::windex_t word_index;
  logic               last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// File: hw/rtl/sha1_stream_hash.sv
// SHA-1 stream hash engine: byte packing, padding, round sequencer and digest output.
//
// The msg channel takes one transaction per message byte; has_byte says whether
// data_byte is valid and end_of_message closes the message, which may be empty.
// The digest channel then gives five transactions, words 0 to 4 of the digest,
// with last_word set on the fifth.
// The engine takes one byte per cycle while it is idle. Each 64th byte starts a compression:
// one round per cycle on the single shared round adder, then a fold of the
// working variables into the chaining words. The message is not ready meanwhile.
// At the end of a message the padding and length bytes go in at one per cycle while
// no compression runs, and one or two compressions take place before the first digest
// word appears. The digest words are held in the chaining registers, so a stalled
// receiver simply holds the block in its output state until all five words are
// taken; after the fifth the engine returns to its initial values.
// Reset returns the engine to the initial hash values with an empty message.
module sha1_stream_hash (
  input  logic           clk,
  input  logic           rst,
  sha1s_msg_if.sink      msg,
  sha1s_digest_if.source digest
);
  import sha1s_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LEN   = 6'b000100,
    S_ROUND = 6'b001000,
    S_FOLD  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t       state;
  state_t       ret;
  word_t        h [DIGEST_WORDS];
  word_t        va, vb, vc, vd, ve;
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [60:0]  count;
  logic [63:0]  len;
  round_t       round;
  windex_t      idx;
  logic         pad_first;

  logic  msg_accept;
  logic  digest_accept;
  word_t f;
  word_t tmp;
  word_t wnew;
  byte_t pad_value;

  assign msg.ready            = (state == S_IDLE);
  assign digest.valid         = (state == S_OUT);
  assign digest.digest_word   = h[idx];
  assign digest.word_index    = idx;
  assign digest.last_word     = (idx == LAST_INDEX);
  assign msg_accept           = msg.valid && msg.ready;
  assign digest_accept        = digest.valid && digest.ready;

  assign pad_value = pad_first ? PAD_BYTE : 8'h00;

  always_comb begin
    word_t x;
    x    = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
    wnew = {x[30:0], x[31]};
    if (round < 7'd20) begin
      f = (vb & vc) | (~vb & vd);
    end else if (round < 7'd40) begin
      f = vb ^ vc ^ vd;
    end else if (round < 7'd60) begin
      f = (vb & vc) | (vb & vd) | (vc & vd);
    end else begin
      f = vb ^ vc ^ vd;
    end
    tmp = {va[26:0], va[31:27]} + f + ve + round_k(round) + blk[511:480];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      fill      <= '0;
      count     <= '0;
      round     <= '0;
      idx       <= '0;
      pad_first <= 1'b0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        h[i] <= IV[i];
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (msg_accept) begin
            pad_first <= 1'b1;
            if (msg.has_byte) begin
              blk   <= {blk[503:0], msg.data_byte};
              fill  <= fill + 6'd1;
              count <= count + 61'd1;
            end
            if (msg.has_byte && fill == 6'd63) begin
              state <= S_ROUND;
              ret   <= msg.end_of_message ? S_PAD : S_IDLE;
              round <= '0;
              va    <= h[0];
              vb    <= h[1];
              vc    <= h[2];
              vd    <= h[3];
              ve    <= h[4];
            end else if (msg.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          blk       <= {blk[503:0], pad_value};
          fill      <= fill + 6'd1;
          pad_first <= 1'b0;
          if (fill == 6'd63) begin
            state <= S_ROUND;
            ret   <= S_PAD;
            round <= '0;
            va    <= h[0];
            vb    <= h[1];
            vc    <= h[2];
            vd    <= h[3];
            ve    <= h[4];
          end else if (fill == 6'd55) begin
            state <= S_LEN;
            len   <= {count, 3'b000};
          end
        end
        S_LEN: begin
          blk  <= {blk[503:0], len[63:56]};
          len  <= {len[55:0], 8'h00};
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_ROUND;
            ret   <= S_OUT;
            round <= '0;
            va    <= h[0];
            vb    <= h[1];
            vc    <= h[2];
            vd    <= h[3];
            ve    <= h[4];
          end
        end
        S_ROUND: begin
          va    <= tmp;
          vb    <= va;
          vc    <= {vb[1:0], vb[31:2]};
          vd    <= vc;
          ve    <= vd;
          blk   <= {blk[479:0], wnew};
          round <= round + 7'd1;
          if (round == LAST_ROUND) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          h[0]  <= h[0] + va;
          h[1]  <= h[1] + vb;
          h[2]  <= h[2] + vc;
          h[3]  <= h[3] + vd;
          h[4]  <= h[4] + ve;
          idx   <= '0;
          state <= ret;
        end
        S_OUT: begin
          if (digest_accept) begin
            if (idx == LAST_INDEX) begin
              idx   <= '0;
              count <= '0;
              state <= S_IDLE;
              for (int i = 0; i < DIGEST_WORDS; i++) begin
                h[i] <= IV[i];
              end
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/sha1s_checker.sv
// Port-level checker for the SHA-1 stream hash engine, bound to its top level.
module sha1s_checker (
  input logic               clk,
  input logic               rst,
  input logic               msg_valid,
  input logic               msg_ready,
  input logic               digest_valid,
  input logic               digest_ready,
  input sha1s_pkg::word_t   digest_word,
  input sha1s_pkg::windex_t word_index,
  input logic               last_word
);
  import sha1s_pkg::*;

  // The engine never takes message bytes while a digest is being delivered.
  assert property (@(posedge clk) disable iff (rst) !(msg_ready && digest_valid))
    else $error("message accepted while a digest is pending");

  // The final flag marks exactly the fifth word.
  assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (last_word == (word_index == LAST_INDEX)))
    else $error("last_word does not match word_index");

  // The five words follow one another, each in the cycle after the previous transaction.
  assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !last_word |=>
      digest_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words not delivered in sequence");

  // A stalled digest word holds its value.
  assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest_word))
    else $error("digest word changed while stalled");

  // No digest is offered straight after reset.
  assert property (@(posedge clk) rst |=> !digest_valid)
    else $error("digest offered after reset");

endmodule

bind sha1_stream_hash sha1s_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .msg_valid    (msg.valid),
  .msg_ready    (msg.ready),
  .digest_valid (digest.valid),
  .digest_ready (digest.ready),
  .digest_word  (digest.digest_word),
  .word_index   (digest.word_index),
  .last_word    (digest.last_word)
);

// File: dv/tb_sha1_stream_hash.sv
// Self-checking testbench for the SHA-1 stream hash engine with its own digest predictor.
module tb_sha1_stream_hash;
  import sha1s_pkg::*;

  typedef struct packed {
    byte_t data_byte;
    logic  has_byte;
    logic  end_of_message;
  } msg_item_t;

  typedef struct packed {
    word_t   digest_word;
    windex_t word_index;
    logic    last_word;
  } digest_exp_t;

  localparam int GAP_MAX = 13;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 310;
  localparam int BOUNDARY_LEN [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha1s_msg_if    msg_bus();
  sha1s_digest_if dig_bus();

  sha1_stream_hash u_top (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_bus),
    .digest (dig_bus)
  );

  always #5 clk = ~clk;

  msg_item_t   msg_q [$];
  digest_exp_t digest_q [$];
  int          errors = 0;
  int          stim_items = 0;

  // Predictor state: chaining words, current block, fill and message length.
  word_t       chain_h [5];
  word_t       blk_w [16];
  logic [5:0]  blk_fill;
  logic [60:0] msg_len;

  function automatic word_t rotl(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_compress();
    word_t w [16];
    word_t a, b, c, d, e, f, k, wt, sum;
    w = blk_w;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        wt = rotl(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15], 1);
        w[t & 15] = wt;
      end else begin
        wt = w[t];
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      sum = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void sha1_pack_byte(byte_t v);
    blk_w[blk_fill[5:2]][8 * (3 - blk_fill[1:0]) +: 8] = v;
    if (blk_fill == 6'd63) begin
      blk_fill = 6'd0;
      sha1_compress();
    end else begin
      blk_fill++;
    end
  endfunction

  function automatic void sha1_chain_init();
    for (int i = 0; i < DIGEST_WORDS; i++) chain_h[i] = IV[i];
    blk_fill = 6'd0;
    msg_len = '0;
  endfunction

  function automatic void sha1_absorb_item(msg_item_t it);
    logic [63:0] nbits;
    digest_exp_t dw;
    if (it.has_byte) begin
      msg_len++;
      sha1_pack_byte(it.data_byte);
    end
    if (it.end_of_message) begin
      nbits = {msg_len, 3'b000};
      sha1_pack_byte(PAD_BYTE);
      while (blk_fill != 6'd56) sha1_pack_byte(8'h00);
      for (int i = 0; i < 8; i++) sha1_pack_byte(nbits[63 - 8 * i -: 8]);
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        dw.digest_word = chain_h[i];
        dw.word_index  = windex_t'(i);
        dw.last_word   = (windex_t'(i) == LAST_INDEX);
        digest_q.push_back(dw);
      end
      sha1_chain_init();
    end
  endfunction

  function automatic void add_item(byte_t v, logic has, logic eom);
    msg_item_t it;
    it.data_byte      = v;
    it.has_byte       = has;
    it.end_of_message = eom;
    msg_q.push_back(it);
    stim_items++;
  endfunction

  // A message of len bytes with occasional empty transactions mixed in.
  function automatic void add_message(int len);
    bit eom_on_byte;
    eom_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) add_item(byte_t'($urandom), 1'b0, 1'b0);
      add_item(byte_t'($urandom), 1'b1, eom_on_byte && (i == len - 1));
    end
    if (!eom_on_byte) add_item(byte_t'($urandom), 1'b0, 1'b1);
  endfunction

  // Transaction sampling, prediction and checking at the rising edge.
  logic        msg_took;
  logic        dig_took;
  int          words_taken = 0;
  digest_exp_t exp_word;

  always @(posedge clk) begin
    if (rst) begin
      msg_took <= 1'b0;
      dig_took <= 1'b0;
    end else begin
      msg_took <= msg_bus.valid && msg_bus.ready;
      dig_took <= dig_bus.valid && dig_bus.ready;
      if (msg_bus.valid && msg_bus.ready) begin
        sha1_absorb_item('{msg_bus.data_byte, msg_bus.has_byte, msg_bus.end_of_message});
      end
      if (dig_bus.valid && dig_bus.ready) begin
        words_taken++;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h index %0d last %b", $time,
                   dig_bus.digest_word, dig_bus.word_index, dig_bus.last_word);
          errors++;
        end else begin
          exp_word = digest_q.pop_front();
          if (dig_bus.digest_word !== exp_word.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp_word.digest_word, dig_bus.digest_word);
            errors++;
          end
          if (dig_bus.word_index !== exp_word.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp_word.word_index, dig_bus.word_index);
            errors++;
          end
          if (dig_bus.last_word !== exp_word.last_word) begin
            $display("%0t: last_word expected %b actual %b", $time,
                     exp_word.last_word, dig_bus.last_word);
            errors++;
          end
        end
      end
    end
  end

  // Message driver.
  logic      msg_on;
  bit        msg_burst = 1'b0;
  int        msg_wait;
  msg_item_t cur_item;

  always @(negedge clk) begin
    if (rst) begin
      msg_on = 1'b0;
      msg_wait = $urandom_range(0, GAP_MAX);
      msg_bus.valid <= 1'b0;
    end else begin
      if (msg_on && msg_took) begin
        msg_on = 1'b0;
        if ($urandom_range(0, 39) == 0) msg_burst = !msg_burst;
        msg_wait = msg_burst ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!msg_on && msg_q.size() != 0) begin
        if (msg_wait > 0) begin
          msg_wait--;
        end else begin
          cur_item = msg_q.pop_front();
          msg_on = 1'b1;
          msg_bus.data_byte      <= cur_item.data_byte;
          msg_bus.has_byte       <= cur_item.has_byte;
          msg_bus.end_of_message <= cur_item.end_of_message;
        end
      end
      msg_bus.valid <= msg_on;
    end
  end

  // Digest receiver, with one long hold-off after the third digest.
  bit dig_burst = 1'b0;
  bit long_done = 1'b0;
  int dig_hold;
  int long_hold = 0;

  always @(negedge clk) begin
    if (rst) begin
      dig_hold = $urandom_range(0, GAP_MAX);
      dig_bus.ready <= 1'b0;
    end else begin
      if (dig_took) begin
        if ($urandom_range(0, 39) == 0) dig_burst = !dig_burst;
        dig_hold = dig_burst ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!long_done && words_taken >= 15 && dig_bus.valid) begin
        long_hold = LONG_HOLD;
        long_done = 1'b1;
      end
      if (long_hold > 0) begin
        long_hold--;
        dig_bus.ready <= 1'b0;
      end else if (dig_hold > 0) begin
        dig_hold--;
        dig_bus.ready <= 1'b0;
      end else begin
        dig_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    int sel;
    int len;
    msg_bus.valid = 1'b0;
    msg_bus.data_byte = '0;
    msg_bus.has_byte = 1'b0;
    msg_bus.end_of_message = 1'b0;
    dig_bus.ready = 1'b0;
    sha1_chain_init();
    for (int i = 0; i < 16; i++) blk_w[i] = '0;

    // Empty message, ignored transaction, bytes closed with the end, then short messages.
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'h55, 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);

    while (stim_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel <= 7) begin
        len = $urandom_range(0, 12);
      end else if (sel == 8) begin
        len = $urandom_range(13, 54);
      end else begin
        len = BOUNDARY_LEN[$urandom_range(0, 7)];
      end
      add_message(len);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (msg_q.size() != 0 || msg_on) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sha1s_pkg.sv
hw/rtl/sha1s_if.sv
hw/rtl/sha1_stream_hash.sv
hw/rtl/sha1s_checker.sv
dv/tb_sha1_stream_hash.sv
